// ===== rtl/ptts_pkg.sv =====
// Package: shared types, codes and sizes for the periodic task tick scheduler.
package ptts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Operation codes
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_CREATE  = 3'd1;
  localparam logic [2:0] FUNC_SUSPEND = 3'd2;
  localparam logic [2:0] FUNC_RESUME  = 3'd3;
  localparam logic [2:0] FUNC_DELETE  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_DUE    = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Command status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_TAKEN  = 2'd2;
  localparam logic [1:0] ST_NOTASK = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot;
    logic [31:0] period;
    logic [31:0] first_delay;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] task_index;
    logic [1:0] status;
    logic       last;
  } res_item_t;

endpackage

// ===== rtl/ptts_slot_mem.sv =====
// Period and countdown storage for all task slots, one registered read port.
module ptts_slot_mem
  import ptts_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic             per_we,
  input  logic [31:0]      per_wdata,
  input  logic             cd_we,
  input  logic [31:0]      cd_wdata,
  output logic [31:0]      per_rdata,
  output logic [31:0]      cd_rdata
);

  logic [31:0] per_mem [NUM_TASKS];
  logic [31:0] cd_mem  [NUM_TASKS];

  // Write ports
  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[wr_addr] <= per_wdata;
    end
    if (cd_we) begin
      cd_mem[wr_addr] <= cd_wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      per_rdata <= per_mem[rd_addr];
      cd_rdata  <= cd_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ptts_cnt_unit.sv =====
// Shared countdown unit: zero test and one decrementer for count or reload.
module ptts_cnt_unit (
  input  logic [31:0] cd,
  input  logic [31:0] per,
  output logic        due,
  output logic [31:0] cd_next
);

  logic [31:0] operand;

  assign due     = (cd == 32'd0);
  // Due slots reload from period, others count down; one subtractor serves both
  assign operand = due ? per : cd;
  assign cd_next = (operand == 32'd0) ? 32'd0 : operand - 32'd1;

endmodule

// ===== rtl/ptts_out_buf.sv =====
// Single-entry result register between the sequencer and the result channel.
module ptts_out_buf
  import ptts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  res_item_t push_item,
  output logic      can_load,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res_item
);

  // Free when empty or when the held result transfers this cycle
  assign can_load = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load) begin
      res_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && can_load) begin
      res_item <= push_item;
    end
  end

endmodule

// ===== rtl/periodic_task_tick_scheduler.sv =====
// Top level: command decode, slot walk sequencer and task state flags.
// Tick: accepted in S_IDLE, then S_READ for each suspended or free slot and S_READ
//   then S_EVAL per running slot (memory read, then countdown update), then S_DONE.
//   The single memory port sets the pace.
// Commands pass from S_IDLE to S_CMD; unknown operations are taken with no result.
// A result appears in the cycle after it is produced; an output stall holds the sequencer.
// Reset (rst, synchronous) frees and suspends every slot and empties the output.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd_item,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res_item
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EVAL = 5'b00100,
    S_CMD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  cmd_item_t             cmd_r;
  logic [IDX_W-1:0]      idx;
  logic [NUM_TASKS-1:0]  slot_used;
  logic [NUM_TASKS-1:0]  slot_running;

  logic        push;
  res_item_t   push_item;
  logic        can_load;

  logic [31:0] per_rdata, cd_rdata;
  logic        due;
  logic [31:0] cd_next;

  logic             cmd_xfer;
  logic             last_idx;
  logic             eval_adv;
  logic [IDX_W-1:0] sel;
  logic             in_range;
  logic             sel_used, sel_run;
  logic [1:0]       st;
  logic             cmd_ok;
  logic             per_we, cd_we;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      per_wdata, cd_wdata;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_xfer  = cmd_valid && !cmd_stall;
  assign last_idx  = (idx == IDX_W'(NUM_TASKS - 1));
  assign eval_adv  = !due || can_load;

  // Command slot decode and status
  assign sel      = cmd_r.slot[IDX_W-1:0];
  assign in_range = (cmd_r.slot < 8'(NUM_TASKS));
  assign sel_used = slot_used[sel];
  assign sel_run  = slot_running[sel];

  always_comb begin
    st = ST_OK;
    if (!in_range) begin
      st = ST_RANGE;
    end else begin
      case (cmd_r.func)
        FUNC_CREATE:  st = sel_used ? ST_TAKEN : ST_OK;
        FUNC_SUSPEND: st = (sel_used && sel_run) ? ST_OK : ST_NOTASK;
        FUNC_RESUME:  st = (sel_used && !sel_run) ? ST_OK : ST_NOTASK;
        FUNC_DELETE:  st = sel_used ? ST_OK : ST_NOTASK;
        default:      st = ST_NOTASK;
      endcase
    end
  end

  assign cmd_ok = (state == S_CMD) && can_load && (st == ST_OK);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          case (cmd_item.func) inside
            FUNC_TICK:                                     state_next = S_READ;
            FUNC_CREATE, FUNC_SUSPEND, FUNC_RESUME, FUNC_DELETE: state_next = S_CMD;
            default:                                       state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (slot_running[idx]) begin
          state_next = S_EVAL;
        end else if (last_idx) begin
          state_next = S_DONE;
        end
      end
      S_EVAL: begin
        if (eval_adv) begin
          state_next = last_idx ? S_DONE : S_READ;
        end
      end
      S_CMD: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latched command
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      cmd_r <= cmd_item;
    end
  end

  // Slot walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd_xfer) begin
      idx <= '0;
    end else if ((state == S_READ && !slot_running[idx] && !last_idx) ||
                 (state == S_EVAL && eval_adv && !last_idx)) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Occupied and running flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used    <= '0;
      slot_running <= '0;
    end else if (cmd_ok) begin
      case (cmd_r.func)
        FUNC_CREATE: begin
          slot_used[sel]    <= 1'b1;
          slot_running[sel] <= 1'b1;
        end
        FUNC_SUSPEND: slot_running[sel] <= 1'b0;
        FUNC_RESUME:  slot_running[sel] <= 1'b1;
        FUNC_DELETE: begin
          slot_used[sel]    <= 1'b0;
          slot_running[sel] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Memory write selection: tick updates countdown, create/delete rewrite the slot
  always_comb begin
    per_we    = 1'b0;
    cd_we     = 1'b0;
    wr_addr   = idx;
    per_wdata = cmd_r.period;
    cd_wdata  = cd_next;
    if (state == S_EVAL) begin
      cd_we = eval_adv;
    end else if (cmd_ok && (cmd_r.func == FUNC_CREATE || cmd_r.func == FUNC_DELETE)) begin
      per_we  = 1'b1;
      cd_we   = 1'b1;
      wr_addr = sel;
      if (cmd_r.func == FUNC_CREATE) begin
        cd_wdata = cmd_r.first_delay;
      end else begin
        per_wdata = 32'd0;
        cd_wdata  = 32'd0;
      end
    end
  end

  // Result selection
  always_comb begin
    push      = 1'b0;
    push_item = '0;
    case (state)
      S_EVAL: begin
        push                 = due;
        push_item.kind       = KIND_DUE;
        push_item.task_index = 8'(idx);
      end
      S_DONE: begin
        push           = 1'b1;
        push_item.kind = KIND_DONE;
        push_item.last = 1'b1;
      end
      S_CMD: begin
        push                 = 1'b1;
        push_item.kind       = KIND_STATUS;
        push_item.task_index = cmd_r.slot;
        push_item.status     = st;
        push_item.last       = 1'b1;
      end
      default: ;
    endcase
  end

  ptts_slot_mem u_mem (
    .clk       (clk),
    .rd_en     (state == S_READ),
    .rd_addr   (idx),
    .wr_addr   (wr_addr),
    .per_we    (per_we),
    .per_wdata (per_wdata),
    .cd_we     (cd_we),
    .cd_wdata  (cd_wdata),
    .per_rdata (per_rdata),
    .cd_rdata  (cd_rdata)
  );

  ptts_cnt_unit u_cnt (
    .cd      (cd_rdata),
    .per     (per_rdata),
    .due     (due),
    .cd_next (cd_next)
  );

  ptts_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ===== rtl/ptts_checker.sv =====
// Port-level assertions for the scheduler, bound to the top level.
module ptts_checker
  import ptts_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input cmd_item_t cmd_item,
  input logic      res_valid,
  input logic      res_stall,
  input res_item_t res_item
);

  // A known operation keeps the block busy for at least the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd_item.func <= FUNC_DELETE) |=> cmd_stall)
    else $error("command transfer not followed by busy");

  // A held result stays put until it transfers
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  // Tick finished is the closing result, with fixed index and status
  a_done_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == KIND_DONE) |->
      res_item.last && (res_item.task_index == 8'd0) && (res_item.status == ST_OK))
    else $error("malformed tick finished result");

  // Due events never close an item and name a real slot
  a_due_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == KIND_DUE) |->
      !res_item.last && (res_item.task_index < 8'(NUM_TASKS)))
    else $error("malformed due event");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result present after reset");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd_item  (cmd_item),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);
